/* hw/rtl/tmi_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Trapezoid motion integrator package
// Shared widths, register indexes and the controller/datapath command types.
// ----------------------------------------------------------------------------
package tmi_pkg;

    localparam int PhaseBitsDefault = 11;
    localparam int StopEpsilon      = 65;

    localparam logic [2:0] REG_MOTION_MODE     = 3'd0;
    localparam logic [2:0] REG_MAX_ACCEL       = 3'd1;
    localparam logic [2:0] REG_MAX_VELOCITY    = 3'd2;
    localparam logic [2:0] REG_POSITION_TARGET = 3'd3;
    localparam logic [2:0] REG_TICK_SECONDS    = 3'd4;

    localparam logic MODE_POSITION = 1'b0;
    localparam logic MODE_VELOCITY = 1'b1;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    typedef struct packed {
        logic capture;
        logic load_pos;
        logic div_start;
        logic choose_accel;
        logic mul_accel;
        logic apply_vel;
        logic mul_delta;
        logic apply_pos;
    } tmi_cmd_t;

    typedef struct packed {
        logic div_done;
        logic stop_dead;
    } tmi_status_t;

endpackage
`default_nettype wire

/* hw/rtl/tmi_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Trapezoid motion integrator divider
// Restoring unsigned divider, one quotient bit per cycle, 64-bit quotient.
// ----------------------------------------------------------------------------
module tmi_divider
    import tmi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [63:0]      quotient
);

    logic [63:0] quo_reg;
    logic [32:0] rem_reg;
    logic [31:0] den_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic [32:0] shifted;
    logic [32:0] diff;

    assign shifted  = {rem_reg[31:0], quo_reg[63]};
    assign diff     = shifted - {1'b0, den_reg};
    assign quotient = quo_reg;
    assign done     = busy_reg && (cnt_reg == 7'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 7'd64;
            quo_reg  <= dividend;
            rem_reg  <= '0;
            den_reg  <= divisor;
        end
        else if (busy_reg && cnt_reg != 7'd0)
        begin
            cnt_reg <= cnt_reg - 7'd1;
            if (!diff[32])
            begin
                rem_reg <= diff;
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/tmi_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Trapezoid motion integrator datapath
// Motion state, registers, multiplier steps and the stopping distance divider.
// ----------------------------------------------------------------------------
module tmi_datapath
    import tmi_pkg::*;
#(
    parameter int PHASE_BITS = PhaseBitsDefault
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire tmi_cmd_t              cmd,
    output tmi_status_t                status,
    input  wire logic                  mode,
    input  wire logic [30:0]           max_accel,
    input  wire logic signed [31:0]    max_velocity,
    input  wire logic signed [63:0]    position_target,
    input  wire logic [15:0]           tick_seconds,
    input  wire logic signed [63:0]    new_position,
    output logic [PHASE_BITS-1:0]      phase_angle,
    output logic signed [63:0]         position_now,
    output logic signed [31:0]         velocity_now,
    output logic signed [31:0]         accel_now
);

    logic signed [63:0] pos_reg;
    logic signed [31:0] vel_reg;
    logic signed [31:0] acc_reg;
    logic signed [31:0] delta_reg;
    logic signed [31:0] prod_reg;
    logic signed [63:0] vsq_reg;

    logic signed [63:0] gap;
    logic signed [63:0] left;
    logic [63:0]        dist_mag;
    logic [63:0]        left_mag;
    logic [63:0]        stop;
    logic [63:0]        div_q;
    logic               div_done;
    logic signed [31:0] pos_acc;
    logic signed [31:0] neg_acc;
    logic signed [48:0] mul_full;
    logic signed [31:0] mul_a;
    logic signed [32:0] vsum;
    logic signed [31:0] vsat;
    logic signed [32:0] neg_lim;
    logic signed [31:0] acc_pick;

    assign pos_acc  = {1'b0, max_accel};
    assign neg_acc  = -pos_acc;
    assign gap      = position_target - pos_reg;
    assign left     = gap - {{32{delta_reg[31]}}, delta_reg};
    assign dist_mag = gap[63] ? -gap : gap;
    assign left_mag = left[63] ? -left : left;
    assign stop     = (max_accel == '0) ? 64'h7FFF_FFFF_FFFF_FFFF : div_q;
    assign neg_lim  = -{max_velocity[31], max_velocity};

    assign mul_a    = cmd.mul_accel ? acc_reg : vel_reg;
    assign mul_full = mul_a * $signed({1'b0, tick_seconds});

    assign vsum = {vel_reg[31], vel_reg} + {prod_reg[31], prod_reg};
    assign vsat = (vsum > 33'sd2147483647) ? 32'sh7FFF_FFFF :
                  (vsum < -33'sd2147483648) ? 32'sh8000_0000 : vsum[31:0];

    tmi_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({vsq_reg[47:0], 16'h0000}),
        .divisor  ({max_accel, 1'b0}),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        acc_pick = acc_reg;
        if (mode == MODE_VELOCITY)
        begin
            if (vel_reg < max_velocity)
                acc_pick = pos_acc;
            else if (vel_reg > max_velocity)
                acc_pick = neg_acc;
        end
        else if (stop >= dist_mag)
            acc_pick = (vel_reg <= 0) ? pos_acc : neg_acc;
        else
            acc_pick = (gap > 0) ? pos_acc : neg_acc;
    end

    assign status.div_done  = div_done || (max_accel == '0);
    assign status.stop_dead = (mode == MODE_POSITION) && (left_mag < 64'(StopEpsilon));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            vel_reg   <= '0;
            acc_reg   <= '0;
            delta_reg <= '0;
            prod_reg  <= '0;
            vsq_reg   <= '0;
        end
        else
        begin
            if (cmd.capture)
                vsq_reg <= (vel_reg * vel_reg) >>> 16;
            if (cmd.load_pos)
                pos_reg <= new_position;
            if (cmd.choose_accel)
            begin
                if (status.stop_dead)
                begin
                    vel_reg <= '0;
                    acc_reg <= '0;
                end
                else
                    acc_reg <= acc_pick;
            end
            if (cmd.mul_accel || cmd.mul_delta)
                prod_reg <= mul_full[47:16];
            if (cmd.apply_vel)
            begin
                if (mode == MODE_VELOCITY)
                begin
                    if (vsat > 0 && max_velocity > 0 && vsat > max_velocity)
                    begin
                        acc_reg <= '0;
                        vel_reg <= max_velocity;
                    end
                    else if (vsat < 0 && max_velocity < 0 && vsat < max_velocity)
                    begin
                        acc_reg <= '0;
                        vel_reg <= max_velocity;
                    end
                    else
                        vel_reg <= vsat;
                end
                else if (vsat >= max_velocity)
                begin
                    acc_reg <= '0;
                    vel_reg <= max_velocity;
                end
                else if ($signed({vsat[31], vsat}) <= neg_lim)
                begin
                    acc_reg <= '0;
                    vel_reg <= neg_lim[31:0];
                end
                else
                    vel_reg <= vsat;
            end
            if (cmd.apply_pos)
            begin
                delta_reg <= prod_reg;
                pos_reg   <= pos_reg + {{32{prod_reg[31]}}, prod_reg};
            end
        end
    end

    assign phase_angle  = pos_reg[PHASE_BITS+6:7];
    assign position_now = pos_reg;
    assign velocity_now = vel_reg;
    assign accel_now    = acc_reg;

endmodule
`default_nettype wire

/* hw/rtl/tmi_controller.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Trapezoid motion integrator controller
// Sequences one request through the datapath and runs the output handshake.
// ----------------------------------------------------------------------------
module tmi_controller
    import tmi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        kind,
    input  wire logic        mode,
    output logic             out_valid,
    input  wire logic        out_stall,
    output tmi_cmd_t         cmd,
    input  wire tmi_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ACCEL,
        ST_MULA,
        ST_VEL,
        ST_MULD,
        ST_POS,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic   skip_reg;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.capture  = in_valid;
                cmd.load_pos = in_valid && (kind == KIND_LOAD);
            end
            ST_DIV:   cmd.div_start    = 1'b0;
            ST_ACCEL: cmd.choose_accel = 1'b1;
            ST_MULA:  cmd.mul_accel    = 1'b1;
            ST_VEL:   cmd.apply_vel    = 1'b1;
            ST_MULD:  cmd.mul_delta    = 1'b1;
            ST_POS:   cmd.apply_pos    = 1'b1;
            default:  cmd = '0;
        endcase
        if (state_reg == ST_DIV && skip_reg)
            cmd.div_start = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            skip_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                    if (in_valid)
                    begin
                        if (kind == KIND_LOAD)
                            state_reg <= ST_OUT;
                        else if (mode == MODE_POSITION)
                        begin
                            state_reg <= ST_DIV;
                            skip_reg  <= 1'b1;
                        end
                        else
                            state_reg <= ST_ACCEL;
                    end
                ST_DIV:
                begin
                    skip_reg <= 1'b0;
                    if (!skip_reg && status.div_done)
                        state_reg <= ST_ACCEL;
                end
                ST_ACCEL:
                    state_reg <= status.stop_dead ? ST_MULD : ST_MULA;
                ST_MULA:  state_reg <= ST_VEL;
                ST_VEL:   state_reg <= ST_MULD;
                ST_MULD:  state_reg <= ST_POS;
                ST_POS:   state_reg <= ST_OUT;
                ST_OUT:
                    if (!out_stall)
                        state_reg <= ST_IDLE;
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/trapezoid_motion_integrator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Trapezoid motion integrator
// Q16.16 motion profile generator: one result per request.
// ----------------------------------------------------------------------------
// A load request loads the position and goes straight to the result. A tick
// in velocity mode steps through the acceleration, velocity and position
// updates; in position mode it first waits for the 64-step stopping distance
// divider, unless the maximum acceleration is zero. A position-mode tick that
// stops dead skips the velocity update. One request is processed at a time;
// the result register holds until taken.
module trapezoid_motion_integrator
    import tmi_pkg::*;
#(
    parameter int PHASE_BITS = PhaseBitsDefault
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [63:0]           cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  kind,
    input  wire logic signed [63:0]    new_position,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [PHASE_BITS-1:0]      phase_angle,
    output logic signed [63:0]         position_now,
    output logic signed [31:0]         velocity_now,
    output logic signed [31:0]         accel_now
);

    logic               mode_reg;
    logic [30:0]        max_accel_reg;
    logic signed [31:0] max_velocity_reg;
    logic signed [63:0] position_target_reg;
    logic [15:0]        tick_seconds_reg;
    tmi_cmd_t           cmd;
    tmi_status_t        status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg            <= MODE_VELOCITY;
            max_accel_reg       <= '0;
            max_velocity_reg    <= '0;
            position_target_reg <= '0;
            tick_seconds_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MOTION_MODE:     mode_reg            <= cfg_data[0];
                REG_MAX_ACCEL:       max_accel_reg       <= cfg_data[30:0];
                REG_MAX_VELOCITY:    max_velocity_reg    <= cfg_data[31:0];
                REG_POSITION_TARGET: position_target_reg <= cfg_data;
                REG_TICK_SECONDS:    tick_seconds_reg    <= cfg_data[15:0];
                default:             ;
            endcase
        end
    end

    tmi_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .mode      (mode_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    tmi_datapath #(.PHASE_BITS(PHASE_BITS)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .mode            (mode_reg),
        .max_accel       (max_accel_reg),
        .max_velocity    (max_velocity_reg),
        .position_target (position_target_reg),
        .tick_seconds    (tick_seconds_reg),
        .new_position    (new_position),
        .phase_angle     (phase_angle),
        .position_now    (position_now),
        .velocity_now    (velocity_now),
        .accel_now       (accel_now)
    );

endmodule
`default_nettype wire

/* hw/rtl/tmi_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Trapezoid motion integrator checker
// Port-level checks of request and result ordering.
// ----------------------------------------------------------------------------
module tmi_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [63:0] position_now
);

    a_no_accept_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("Request accepted while a result is pending.");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(position_now))
        else $error("Stalled result changed.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("Block accepted a second request while one is in flight.");

    a_idle_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid && !in_stall)
        else $error("Block not idle after result taken.");

endmodule

bind trapezoid_motion_integrator tmi_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .position_now (position_now)
);
`default_nettype wire
